@@ rtl/cal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the request and response
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // width wide enough to compare an index against the count
    localparam int CMP_W    = (CNT_W > INDEX_W + 1) ? CNT_W : INDEX_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_READ   = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_REWIND = 3'd3,
        CMD_NEXT   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ rtl/cal_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cal_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cal_pkg::CMD_W-1:0]     command;
    logic signed [cal_pkg::VALUE_W-1:0]   value;
    logic        [cal_pkg::INDEX_W-1:0]   index;

    modport source (output valid, command, value, index, input ready);
    modport sink   (input valid, command, value, index, output ready);
endinterface

interface cal_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cal_pkg::VALUE_W-1:0]   data;
    logic        [cal_pkg::STATUS_W-1:0]  status;
    logic        [cal_pkg::COUNT_W-1:0]   count;

    modport source (output valid, data, status, count, input ready);
    modport sink   (input valid, data, status, count, output ready);
endinterface

`default_nettype wire

@@ rtl/compacting_array_list_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Modport  Payload
// i_req     in   sink     command[2:0], value[31:0] signed, index[5:0]
// o_rsp     out  source   data[31:0] signed, status[1:0], count[6:0]
//
// Append, rewind, unused commands and out-of-range requests go from idle
// to the output state; read and read-next pass the read state first, as
// does remove, which then moves each entry after index i down in the shift
// state, one entry per cycle through the RAM's single read and single write
// port. Reset clears state, count, cursor and output valid; the entry RAM
// is not cleared. A finished response waits in the output register while
// the next request is taken; the unit holds its result while it is occupied.
module compacting_array_list_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cal_req_if.sink    i_req,
    cal_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_SHIFT = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    cal_pkg::t_cmd                     r_cmd, n_cmd;
    logic [cal_pkg::ADDR_W-1:0]        r_k, n_k;
    logic [cal_pkg::CNT_W-1:0]         r_count, n_count;
    logic [cal_pkg::CNT_W-1:0]         r_cursor, n_cursor;
    logic [cal_pkg::VALUE_W-1:0]       r_res_data, n_res_data;
    cal_pkg::t_status                  r_res_status, n_res_status;
    logic                              r_out_valid, n_out_valid;
    logic [cal_pkg::VALUE_W-1:0]       r_out_data, n_out_data;
    cal_pkg::t_status                  r_out_status, n_out_status;
    logic [cal_pkg::COUNT_W-1:0]       r_out_count, n_out_count;

    logic                              ram_we;
    logic [cal_pkg::ADDR_W-1:0]        ram_waddr;
    logic [cal_pkg::VALUE_W-1:0]       ram_wdata;
    logic [cal_pkg::ADDR_W-1:0]        ram_raddr;
    logic [cal_pkg::VALUE_W-1:0]       ram_rdata;

    logic                              accept;
    logic                              idx_ok;
    logic [cal_pkg::CNT_W-1:0]         kp1, kp2;

    cal_ram #(
        .DEPTH (cal_pkg::CAPACITY),
        .WIDTH (cal_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && i_req.ready;
    assign idx_ok       = cal_pkg::CMP_W'(i_req.index) < cal_pkg::CMP_W'(r_count);
    assign kp1          = cal_pkg::CNT_W'(r_k) + cal_pkg::CNT_W'(1);
    assign kp2          = cal_pkg::CNT_W'(r_k) + cal_pkg::CNT_W'(2);

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.status = r_out_status;
    assign o_rsp.count  = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_k          = r_k;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_count[cal_pkg::ADDR_W-1:0];
        ram_wdata    = i_req.value;
        ram_raddr    = r_k;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd        = cal_pkg::t_cmd'(i_req.command);
                    n_res_data   = '0;
                    n_res_status = cal_pkg::ST_OK;
                    n_state      = S_OUT;
                    case (cal_pkg::t_cmd'(i_req.command))
                        cal_pkg::CMD_APPEND: begin
                            if (r_count >= cal_pkg::CNT_W'(cal_pkg::CAPACITY)) begin
                                n_res_status = cal_pkg::ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + cal_pkg::CNT_W'(1);
                            end
                        end
                        cal_pkg::CMD_READ, cal_pkg::CMD_REMOVE: begin
                            if (idx_ok) begin
                                ram_raddr = cal_pkg::ADDR_W'(i_req.index);
                                n_k       = cal_pkg::ADDR_W'(i_req.index);
                                n_state   = S_RD;
                            end else begin
                                n_res_status = cal_pkg::ST_RANGE;
                            end
                        end
                        cal_pkg::CMD_REWIND: begin
                            n_cursor = '0;
                        end
                        cal_pkg::CMD_NEXT: begin
                            if (r_cursor < r_count) begin
                                ram_raddr = r_cursor[cal_pkg::ADDR_W-1:0];
                                n_state   = S_RD;
                            end else begin
                                n_res_status = cal_pkg::ST_RANGE;
                            end
                            if (r_cursor < cal_pkg::CNT_W'(cal_pkg::CAPACITY)) begin
                                n_cursor = r_cursor + cal_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            n_res_status = cal_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_res_data = ram_rdata;
                n_state    = S_OUT;
                if (r_cmd == cal_pkg::CMD_REMOVE) begin
                    if (kp1 < r_count) begin
                        // fetch the first entry to move down
                        ram_raddr = kp1[cal_pkg::ADDR_W-1:0];
                        n_state   = S_SHIFT;
                    end else begin
                        n_count = r_count - cal_pkg::CNT_W'(1);
                    end
                end
            end
            S_SHIFT: begin
                // entry k+1 arrives now; write it to k and fetch k+2 if it is in the list
                ram_we    = 1'b1;
                ram_waddr = r_k;
                ram_wdata = ram_rdata;
                n_k       = kp1[cal_pkg::ADDR_W-1:0];
                if (kp2 < r_count) begin
                    ram_raddr = kp2[cal_pkg::ADDR_W-1:0];
                end else begin
                    n_count = r_count - cal_pkg::CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_count  = cal_pkg::COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_k          <= n_k;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= cal_pkg::CNT_W'(cal_pkg::CAPACITY))
        else $error("read cursor above capacity");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (kp1 < r_count))
        else $error("shift step outside the list");

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !$past(o_rsp.valid)) |-> $past(r_state == S_OUT))
        else $error("response loaded outside output stage");

endmodule

`default_nettype wire

@@ rtl/cal_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cal_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
